### rtl/lfp_pkg.sv
// ---------------------------------------------------------------------------
// lfp_pkg: shared types and constants for the lidar frame parser
// Frame positions, status codes and the result bundle passed between the
// parser core and the top level.
// ---------------------------------------------------------------------------
`default_nettype none

package lfp_pkg;

  localparam int unsigned FRAME_BYTES = 9;
  localparam int unsigned POS_W       = 4;

  typedef logic [POS_W-1:0] pos_t;

  // frame byte positions
  localparam pos_t POS_HDR0  = 4'd0;
  localparam pos_t POS_HDR1  = 4'd1;
  localparam pos_t POS_DIST0 = 4'd2;
  localparam pos_t POS_DIST1 = 4'd3;
  localparam pos_t POS_STR0  = 4'd4;
  localparam pos_t POS_STR1  = 4'd5;
  localparam pos_t POS_QUAL  = 4'd6;
  localparam pos_t POS_SPARE = 4'd7;
  localparam pos_t POS_CSUM  = 4'd8;

  localparam logic [7:0] HEADER_RESET = 8'h59;
  localparam logic [7:0] RELIABLE_A   = 8'd7;
  localparam logic [7:0] RELIABLE_B   = 8'd8;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK         = 2'd0;
  localparam status_t STATUS_UNRELIABLE = 2'd1;
  localparam status_t STATUS_BAD_SUM    = 2'd2;

  typedef struct packed {
    logic          emit;
    logic [15:0]   distance_cm;
    logic [15:0]   strength;
    status_t       status;
  } lfp_result_t;

endpackage

`default_nettype wire

### rtl/lfp_frame_core.sv
// ---------------------------------------------------------------------------
// lfp_frame_core: frame state and per-byte decode
// Holds the byte position, running checksum and payload being built; decodes
// one byte per step and reports a result on the checksum byte.
// ---------------------------------------------------------------------------
`default_nettype none

module lfp_frame_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire logic [7:0]          rx_byte,
  input  wire logic [7:0]          header_value,
  output lfp_pkg::lfp_result_t     result
);
  import lfp_pkg::*;

  pos_t        pos_r, pos_nxt, pos_eff;
  logic [7:0]  sum_r, sum_nxt;
  logic [15:0] dist_r, dist_nxt;
  logic [15:0] str_r, str_nxt;
  logic [7:0]  qual_r, qual_nxt;
  logic [7:0]  sum_add;

  // out-of-range position falls back to header hunting
  assign pos_eff = (pos_r > POS_CSUM) ? POS_HDR0 : pos_r;
  assign sum_add = sum_r + rx_byte;

  always_comb begin
    pos_nxt  = pos_eff + 4'd1;
    sum_nxt  = sum_add;
    dist_nxt = dist_r;
    str_nxt  = str_r;
    qual_nxt = qual_r;

    result.emit        = 1'b0;
    result.distance_cm = dist_r;
    result.strength    = str_r;
    result.status      = STATUS_OK;

    case (pos_eff)
      POS_HDR0: begin
        if (rx_byte == header_value) begin
          sum_nxt = rx_byte;
        end else begin
          pos_nxt = POS_HDR0;
          sum_nxt = sum_r;
        end
      end
      POS_HDR1: begin
        if (rx_byte != header_value) begin
          pos_nxt = POS_HDR0;
          sum_nxt = sum_r;
        end
      end
      POS_DIST0: dist_nxt = {8'h00, rx_byte};
      POS_DIST1: dist_nxt = {rx_byte, dist_r[7:0]};
      POS_STR0:  str_nxt  = {8'h00, rx_byte};
      POS_STR1:  str_nxt  = {rx_byte, str_r[7:0]};
      POS_QUAL:  qual_nxt = rx_byte;
      POS_SPARE: ;
      default: begin
        // checksum byte: close the frame
        pos_nxt     = POS_HDR0;
        sum_nxt     = 8'h00;
        result.emit = 1'b1;
        if (sum_r != rx_byte) begin
          result.distance_cm = 16'h0000;
          result.strength    = 16'h0000;
          result.status      = STATUS_BAD_SUM;
        end else if (qual_r inside {RELIABLE_A, RELIABLE_B}) begin
          result.status = STATUS_OK;
        end else begin
          result.status = STATUS_UNRELIABLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_HDR0;
      sum_r  <= 8'h00;
      dist_r <= 16'h0000;
      str_r  <= 16'h0000;
      qual_r <= 8'h00;
    end else if (step) begin
      pos_r  <= pos_nxt;
      sum_r  <= sum_nxt;
      dist_r <= dist_nxt;
      str_r  <= str_nxt;
      qual_r <= qual_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/lidar_frame_parser_top.sv
// ---------------------------------------------------------------------------
// lidar_frame_parser_top: 9-byte lidar serial frame parser
// Hunts for two header bytes, gathers distance, strength and reliability,
// checks the 8-bit sum and emits one result per complete frame.
// ---------------------------------------------------------------------------
//
//  Channel  | Ports                                         | Direction
//  ---------+-----------------------------------------------+----------
//  input    | in_valid, in_stall, in_rx_byte                | in
//  result   | out_valid, out_stall, out_distance_cm,        | out
//           | out_strength, out_status                      |
//  config   | cfg_wr_en, cfg_wr_data (header byte)          | in
//
//  One byte is taken per cycle when nothing downstream is blocked.
//  A byte is registered in the input register and decoded from there; a
//  result is loaded into the output register as its checksum byte is
//  decoded.
//  The input register is held only when it carries a checksum byte and the
//  output register still holds an untaken result; other bytes pass freely.
//  Synchronous active-low reset clears the frame state, both valid flags and
//  restores the header byte to 0x59.
//
`default_nettype none

module lidar_frame_parser_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire logic [7:0]          in_rx_byte,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      logic [15:0]         out_distance_cm,
  output      logic [15:0]         out_strength,
  output      lfp_pkg::status_t    out_status,
  input  wire logic                cfg_wr_en,
  input  wire logic [7:0]          cfg_wr_data
);
  import lfp_pkg::*;

  logic [7:0]  header_r;
  logic        in_vld_r, in_vld_nxt;
  logic [7:0]  in_byte_r;
  logic        in_take;
  logic        advance;
  logic        out_free;
  logic        out_vld_r, out_vld_nxt;
  logic [15:0] out_dist_r;
  logic [15:0] out_str_r;
  status_t     out_status_r;
  lfp_result_t result;

  // header byte register, written directly from the configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= HEADER_RESET;
    end else if (cfg_wr_en) begin
      header_r <= cfg_wr_data;
    end
  end

  // output slot is free when empty or being drained this cycle
  assign out_free = !out_vld_r || !out_stall;

  // decode the held byte unless it would emit into a blocked output slot
  assign advance  = in_vld_r && (!result.emit || out_free);

  // hold the input transaction only while the held byte cannot move on
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_rx_byte;
    end
  end

  lfp_frame_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .rx_byte      (in_byte_r),
    .header_value (header_r),
    .result       (result)
  );

  // result register: load on a frame close, drop once the transaction is taken
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (advance && result.emit) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.emit) begin
      out_dist_r   <= result.distance_cm;
      out_str_r    <= result.strength;
      out_status_r <= result.status;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_distance_cm = out_dist_r;
  assign out_strength    = out_str_r;
  assign out_status      = out_status_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // the status code never takes the unused value
  a_status_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_status_r == STATUS_OK || out_status_r == STATUS_UNRELIABLE ||
                   out_status_r == STATUS_BAD_SUM))
    else $error("result status outside defined codes");

  // a checksum failure carries zeroed measurement values
  a_bad_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_status_r == STATUS_BAD_SUM) |->
      (out_dist_r == 16'h0000 && out_str_r == 16'h0000))
    else $error("checksum failure with non-zero payload");

  // input is held back only for a checksum byte facing a blocked output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_vld_r && result.emit && out_vld_r && out_stall))
    else $error("input stalled without a blocked result");

  // a stalled input byte is still held on the next cycle
  a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> in_vld_r)
    else $error("held input byte lost");

endmodule

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Lidar frame parser testbench
// Sends serial bytes into the parser as whole frames, broken frames and
// noise, under several header byte settings, with random gaps and stalls on
// both sides. Every reading is checked against a predicted one.
// ---------------------------------------------------------------------------

module testbench;
  import lfp_pkg::*;

  // one decoded reading, as it leaves the parser
  typedef struct packed {
    logic [15:0] distance;
    logic [15:0] strength;
    status_t     status;
  } reading_t;

  // Tracks the frame decoder in step with the block and holds the readings
  // that are still to come out of it.
  class reading_book;
    logic [7:0]  header;
    pos_t        pos;
    logic [7:0]  sum;
    logic [15:0] dist_acc;
    logic [15:0] str;
    logic [7:0]  quality;
    reading_t    awaited[$];
    int          failures;
    int          n_ok;
    int          n_unreliable;
    int          n_bad_sum;

    function new();
      header       = HEADER_RESET;
      pos          = POS_HDR0;
      sum          = 8'h00;
      dist_acc     = 16'h0000;
      str          = 16'h0000;
      quality      = 8'h00;
      failures     = 0;
      n_ok         = 0;
      n_unreliable = 0;
      n_bad_sum    = 0;
    endfunction

    function void set_header(logic [7:0] value);
      header = value;
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    function void absorb(logic [7:0] b);
      sum = sum + b;
      pos = pos + 1'b1;
    endfunction

    // advance the decoder by one accepted byte
    function void take_byte(logic [7:0] b);
      reading_t r;
      if (pos > POS_CSUM) pos = POS_HDR0;
      case (pos)
        POS_HDR0: begin
          if (b == header) begin
            sum = 8'h00;
            absorb(b);
          end
        end
        POS_HDR1: begin
          if (b == header) absorb(b);
          else pos = POS_HDR0;
        end
        POS_DIST0: begin
          dist_acc = {8'h00, b};
          absorb(b);
        end
        POS_DIST1: begin
          dist_acc = {b, dist_acc[7:0]};
          absorb(b);
        end
        POS_STR0: begin
          str = {8'h00, b};
          absorb(b);
        end
        POS_STR1: begin
          str = {b, str[7:0]};
          absorb(b);
        end
        POS_QUAL: begin
          quality = b;
          absorb(b);
        end
        POS_SPARE: absorb(b);
        default: begin
          pos = POS_HDR0;
          if (sum != b) begin
            r.distance = 16'h0000;
            r.strength = 16'h0000;
            r.status   = STATUS_BAD_SUM;
          end else begin
            r.distance = dist_acc;
            r.strength = str;
            r.status   = (quality == RELIABLE_A || quality == RELIABLE_B) ?
                         STATUS_OK : STATUS_UNRELIABLE;
          end
          sum = 8'h00;
          awaited.push_back(r);
        end
      endcase
    endfunction

    function void match_reading(logic [15:0] distance, logic [15:0] strength,
                                status_t status);
      reading_t e;
      if (awaited.size() == 0) begin
        failures++;
        $display("%0t: unexpected reading distance=%h strength=%h status=%0d",
                 $time, distance, strength, status);
        return;
      end
      e = awaited.pop_front();
      if (distance !== e.distance) begin
        failures++;
        $display("%0t: distance mismatch expected=%h actual=%h",
                 $time, e.distance, distance);
      end
      if (strength !== e.strength) begin
        failures++;
        $display("%0t: strength mismatch expected=%h actual=%h",
                 $time, e.strength, strength);
      end
      if (status !== e.status) begin
        failures++;
        $display("%0t: status mismatch expected=%0d actual=%0d",
                 $time, e.status, status);
      end
      case (e.status)
        STATUS_OK:         n_ok++;
        STATUS_UNRELIABLE: n_unreliable++;
        default:           n_bad_sum++;
      endcase
    endfunction
  endclass

  // every input starts at a known value
  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic [7:0]  in_rx_byte  = 8'h00;
  logic        out_stall   = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [7:0]  cfg_wr_data = 8'h00;
  logic        in_stall;
  logic        out_valid;
  logic [15:0] out_distance_cm;
  logic [15:0] out_strength;
  status_t     out_status;

  // while set, neither side idles: gives one long unbroken stretch
  logic        steady = 1'b0;
  int          frame_bytes_sent = 0;
  int          settings_used = 1;
  reading_book book;

  always #6 clk = ~clk;

  lidar_frame_parser_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_distance_cm (out_distance_cm),
    .out_strength    (out_strength),
    .out_status      (out_status),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  // Result side: values seen here are those from before the edge, so a
  // transaction is taken exactly when valid was high and stall low. Then pick
  // the stall level for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      book.match_reading(out_distance_cm, out_strength, out_status);
    out_stall <= steady ? 1'b0 : ($urandom_range(99) < 25);
  end

  // Offer one byte and hold it until the parser takes it. Called just after
  // a rising edge; on return the transaction has completed at that edge.
  task automatic push_byte(input logic [7:0] b);
    if (!steady && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    book.take_byte(b);
  endtask

  // Build a frame around the given payload; a non-zero flip corrupts the
  // checksum byte.
  task automatic send_frame(input logic [15:0] distance, input logic [15:0] strength,
                            input logic [7:0] quality, input logic [7:0] spare,
                            input logic [7:0] flip);
    logic [7:0] bytes[9];
    logic [7:0] total;
    total = 8'h00;
    bytes[0] = book.header;
    bytes[1] = book.header;
    bytes[2] = distance[7:0];
    bytes[3] = distance[15:8];
    bytes[4] = strength[7:0];
    bytes[5] = strength[15:8];
    bytes[6] = quality;
    bytes[7] = spare;
    for (int i = 0; i < 8; i++) total = total + bytes[i];
    bytes[8] = total ^ flip;
    for (int i = 0; i < 9; i++) push_byte(bytes[i]);
    frame_bytes_sent += 9;
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly well-formed frames with random payload; the rest is line noise,
  // a wrong second header or a frame cut short.
  task automatic random_traffic(input int target);
    int         goal;
    int         pick;
    logic [7:0] quality;
    logic [7:0] flip;
    goal = frame_bytes_sent + target;
    while (frame_bytes_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        case ($urandom_range(3))
          0:       quality = RELIABLE_A;
          1:       quality = RELIABLE_B;
          default: quality = 8'($urandom);
        endcase
        flip = ($urandom_range(99) < 20) ? 8'($urandom_range(1, 255)) : 8'h00;
        send_frame(pick_word(), pick_word(), quality, 8'($urandom), flip);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
      end else if (pick < 92) begin
        push_byte(book.header);
        push_byte(book.header ^ 8'($urandom_range(1, 255)));
      end else begin
        push_byte(book.header);
        push_byte(book.header);
        repeat ($urandom_range(0, 6)) begin
          push_byte(8'($urandom));
          frame_bytes_sent++;
        end
        frame_bytes_sent += 2;
      end
    end
  endtask

  // Drop valid, wait for every reading to come out, then let the pipeline
  // empty of bytes that produce nothing.
  task automatic drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (book.outstanding() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic load_header(input logic [7:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    book.set_header(value);
    settings_used++;
  endtask

  initial begin
    logic [7:0] setting[5];
    book = new();
    setting[0] = HEADER_RESET;
    setting[1] = 8'h00;
    setting[2] = 8'hFF;
    setting[3] = 8'($urandom);
    setting[4] = HEADER_RESET;

    // hold reset low, then release it
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: a header followed by a wrong second header, a good frame at
    // the payload extremes, an unreliable one, and a bad checksum that must
    // win over an unreliable quality byte
    push_byte(HEADER_RESET);
    push_byte(8'h00);
    send_frame(16'hFFFF, 16'h0000, RELIABLE_A, 8'hFF, 8'h00);
    send_frame(16'h0000, 16'hFFFF, 8'h00, 8'h00, 8'h00);
    send_frame(16'h1234, 16'hABCD, 8'hFF, 8'h55, 8'h01);

    // random traffic under each header setting; the third one runs with
    // neither side idling
    for (int phase = 0; phase < 5; phase++) begin
      if (phase > 0) begin
        drain();
        load_header(setting[phase]);
      end
      steady = (phase == 2);
      random_traffic(320);
    end
    steady = 1'b0;
    drain();

    if (book.outstanding() != 0) begin
      book.failures += book.outstanding();
      $display("%0t: %0d readings never arrived", $time, book.outstanding());
    end
    $display("Covered %0d frame bytes over %0d header settings.",
             frame_bytes_sent, settings_used);
    $display("Readings checked: %0d ok, %0d unreliable, %0d checksum errors.",
             book.n_ok, book.n_unreliable, book.n_bad_sum);
    if (book.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
